// ----- src/sidv_pkg.sv -----
// Shared types and constants for the disk image validator.
package sidv_pkg;

  // Kind of one result transaction.
  typedef enum logic [1:0] {
    RK_SECTOR = 2'd0,
    RK_ACCEPT = 2'd1,
    RK_ERROR  = 2'd2
  } result_kind_e;

  // Error codes carried with an error result.
  typedef enum logic [3:0] {
    EC_NONE    = 4'd0,
    EC_HEADER  = 4'd1,
    EC_TRUNC   = 4'd2,
    EC_EXTENT  = 4'd3,
    EC_FUZZY   = 4'd4,
    EC_SIZE    = 4'd5,
    EC_PAYLOAD = 4'd6,
    EC_IDENT   = 4'd7,
    EC_DUP     = 4'd8,
    EC_TCOUNT  = 4'd9
  } error_code_e;

  // Record length of headers and descriptors.
  localparam logic [31:0] RecBytes  = 32'd16;
  localparam logic [3:0]  RecLast   = 4'd15;
  localparam logic [7:0]  MagicR    = 8'h52;
  localparam logic [7:0]  MagicS    = 8'h53;
  localparam logic [7:0]  MagicY    = 8'h59;
  localparam logic [7:0]  FmtVer    = 8'd3;
  localparam logic [14:0] BaseSize  = 15'd128;
  localparam logic [8:0]  SeenMax   = 9'd256;

  // One classified image byte, from the front to the back.
  typedef struct packed {
    logic [7:0]  data;
    logic [31:0] pos;
    logic        last;
    logic        trunc;
    logic        short_img;
  } item_t;

  // One result transaction.
  typedef struct packed {
    result_kind_e kind;
    error_code_e  err;
    logic [6:0]   trk;
    logic         side;
    logic [7:0]   num;
    logic [2:0]   code;
    logic [7:0]   flags;
    logic [31:0]  off;
    logic [14:0]  size;
  } result_t;

endpackage

// ----- src/stx_disk_image_validator_top.sv -----
// Top level of the disk image validator: configuration register and the front, queue and back.
//
// Usage: image bytes enter on the input channel (in_valid_i, in_stall_o,
// image_byte_i), one byte per transaction, in file order. Images follow one
// another back to back; each is image_length bytes long, set through the
// APB port (register 0 at byte address 0, reset value 16).
// Results leave on the output channel (out_valid_o, out_stall_i): a sector
// record per valid descriptor, then one accepted or error status per image.
// After an error the rest of that image is consumed without results.
// Throughput is one byte per cycle while the output is not stalled, set by
// the single parse step in the back end. A byte that causes a result passes
// through the queue, and the result leaves from the output register.
// When the receiver stalls, the output register holds, the back end stops,
// the two-entry queue fills, and in_stall_o rises.
// Reset clears the parser, the queue, and the seen-sector valid bits; no
// clearing pass is needed and bytes are taken right after reset.
module stx_disk_image_validator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  image_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [3:0]  error_code_o,
  output logic [6:0]  sector_track_o,
  output logic        sector_side_o,
  output logic [7:0]  sector_number_o,
  output logic [2:0]  size_code_o,
  output logic [7:0]  sector_flags_o,
  output logic [31:0] payload_offset_o,
  output logic [14:0] payload_size_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sidv_pkg::*;

  logic [31:0] len_q;
  logic        push, full, pop, head_vld;
  item_t       fr_item, head;
  result_t     res;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= RecBytes;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      len_q <= pwdata;
    end
  end

  sidv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .image_byte_i (image_byte_i),
    .len_i        (len_q),
    .full_i       (full),
    .push_o       (push),
    .item_o       (fr_item)
  );

  sidv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (fr_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_vld),
    .item_o  (head)
  );

  sidv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .len_i        (len_q),
    .item_valid_i (head_vld),
    .item_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res)
  );

  // Result fields.
  assign result_kind_o    = res.kind;
  assign error_code_o     = res.err;
  assign sector_track_o   = res.trk;
  assign sector_side_o    = res.side;
  assign sector_number_o  = res.num;
  assign size_code_o      = res.code;
  assign sector_flags_o   = res.flags;
  assign payload_offset_o = res.off;
  assign payload_size_o   = res.size;
endmodule

// ----- src/sidv_ram.sv -----
// Generic single-port-write RAM with a registered read port.
module sidv_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- src/sidv_front.sv -----
// Front end: accepts image bytes, tracks the byte position and classifies each byte.
module sidv_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      image_byte_i,
  input  logic [31:0]     len_i,
  input  logic            full_i,
  output logic            push_o,
  output sidv_pkg::item_t item_o
);
  import sidv_pkg::*;

  logic [31:0] pos_q, pos_d;
  logic [32:0] pos_p1;
  logic        last;

  // Position-relative flags against the image length.
  assign pos_p1 = {1'b0, pos_q} + 33'd1;
  assign last   = pos_p1 >= {1'b0, len_i};

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    item_o.data      = image_byte_i;
    item_o.pos       = pos_q;
    item_o.last      = last;
    item_o.trunc     = {1'b0, len_i} < ({1'b0, pos_q} + {1'b0, RecBytes});
    item_o.short_img = (pos_q == '0) && (len_i < RecBytes);
  end

  // The position wraps to zero after the last byte of an image.
  assign pos_d = last ? '0 : pos_p1[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (push_o) begin
      pos_q <= pos_d;
    end
  end
endmodule

// ----- src/sidv_fifo.sv -----
// Two-entry queue between the front and the back.
module sidv_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sidv_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output sidv_pkg::item_t item_o
);
  import sidv_pkg::*;

  item_t       mem_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign item_o  = mem_q[rptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

// ----- src/sidv_back.sv -----
// Back end: parses headers and descriptors, checks them and produces results.
module sidv_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       len_i,
  input  logic              item_valid_i,
  input  sidv_pkg::item_t   item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sidv_pkg::result_t res_o
);
  import sidv_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_TRK,
    PH_DSC,
    PH_SKP,
    PH_FIN
  } phase_e;

  phase_e       phase_q, phase_d;
  logic [3:0]   fs_q, fs_d;
  logic [31:0]  ts_q, ts_d;
  logic [32:0]  tend_q, tend_d;
  logic [31:0]  base_q, base_d;
  logic [31:0]  room_q, room_d;
  logic [15:0]  cnt_q, cnt_d;
  logic [15:0]  sidx_q, sidx_d;
  logic [7:0]   tid_q, tid_d;
  logic [7:0]   decl_q, decl_d;
  logic [8:0]   seen_q, seen_d;
  logic [255:0] rowv_q, rowv_d;
  logic         out_vld_q, out_vld_d;
  result_t      res_q, res_d, res_new;
  logic         res_hit;
  logic [7:0]   desc_q [16];
  logic         desc_we;

  logic [32:0]  pos_p1;
  logic [31:0]  blk, fuzzy, remain, room0, off, cnt16;
  logic [15:0]  cnt;
  logic         hdr_bad, f3, f4, f5, f6, f7, f8;
  logic [14:0]  psize;
  logic [255:0] rdata, row_cur, row_new;
  logic         ram_we;

  function automatic result_t err_res(error_code_e c);
    result_t r;
    r      = '0;
    r.kind = RK_ERROR;
    r.err  = c;
    return r;
  endfunction

  function automatic result_t final_res(logic ok);
    result_t r;
    r      = '0;
    r.kind = ok ? RK_ACCEPT : RK_ERROR;
    r.err  = ok ? EC_NONE : EC_TCOUNT;
    return r;
  endfunction

  assign pop_o       = item_valid_i && (!out_vld_q || !out_stall_i);
  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;
  assign pos_p1      = {1'b0, item_i.pos} + 33'd1;

  // File header check.
  assign hdr_bad = (len_i < RecBytes) || (desc_q[0] != MagicR) || (desc_q[1] != MagicS)
                || (desc_q[2] != MagicY) || (desc_q[3] != 8'd0) || (desc_q[4] != FmtVer)
                || (desc_q[5] != 8'd0);

  // Track header extent and fuzzy checks.
  assign blk    = {desc_q[3], desc_q[2], desc_q[1], desc_q[0]};
  assign fuzzy  = {desc_q[7], desc_q[6], desc_q[5], desc_q[4]};
  assign cnt    = {desc_q[9], desc_q[8]};
  assign cnt16  = {12'd0, cnt, 4'd0};
  assign remain = (len_i > ts_q) ? (len_i - ts_q) : '0;
  assign f3     = (blk < RecBytes) || (blk > remain)
               || ({16'd0, cnt} > ((blk - RecBytes) >> 4));
  assign room0  = blk - RecBytes - cnt16;
  assign f4     = fuzzy > room0;

  // Sector descriptor checks.
  assign off   = blk;
  assign psize = BaseSize << desc_q[11][2:0];
  assign f5    = desc_q[11] > 8'd7;
  assign f6    = (off > room_q) || ({17'd0, psize} > (room_q - off));
  assign f7    = (desc_q[8] != {1'b0, tid_q[6:0]}) || (desc_q[9] != {7'd0, tid_q[7]});
  assign row_cur = rowv_q[tid_q] ? rdata : '0;
  assign f8      = row_cur[desc_q[10]];
  assign row_new = row_cur | (256'd1 << desc_q[10]);

  // Seen-sector map: one row per track byte, one bit per sector number.
  sidv_ram #(
    .Width (256),
    .Depth (256)
  ) u_seen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tid_q),
    .wdata_i (row_new),
    .re_i    (1'b1),
    .raddr_i (tid_q),
    .rdata_o (rdata)
  );

  // Parse step for one byte.
  always_comb begin
    phase_d   = phase_q;
    fs_d      = fs_q;
    ts_d      = ts_q;
    tend_d    = tend_q;
    base_d    = base_q;
    room_d    = room_q;
    cnt_d     = cnt_q;
    sidx_d    = sidx_q;
    tid_d     = tid_q;
    decl_d    = decl_q;
    seen_d    = seen_q;
    rowv_d    = rowv_q;
    desc_we   = 1'b0;
    ram_we    = 1'b0;
    res_hit   = 1'b0;
    res_new   = '0;
    res_d     = res_q;
    out_vld_d = out_vld_q && out_stall_i;
    if (pop_o) begin
      case (phase_q)
        PH_HDR: begin
          if (item_i.short_img) begin
            res_hit = 1'b1;
            res_new = err_res(EC_HEADER);
            phase_d = PH_FIN;
          end else begin
            desc_we = 1'b1;
            if (fs_q == RecLast) begin
              if (hdr_bad) begin
                res_hit = 1'b1;
                res_new = err_res(EC_HEADER);
                phase_d = PH_FIN;
              end else begin
                decl_d = desc_q[10];
                seen_d = '0;
                fs_d   = '0;
                if (len_i <= RecBytes) begin
                  res_hit = 1'b1;
                  res_new = final_res(desc_q[10] == 8'd0);
                  phase_d = PH_FIN;
                end else begin
                  phase_d = PH_TRK;
                end
              end
            end else begin
              fs_d = fs_q + 4'd1;
            end
          end
        end
        PH_TRK: begin
          if (fs_q == '0) begin
            ts_d = item_i.pos;
          end
          if ((fs_q == '0) && item_i.trunc) begin
            res_hit = 1'b1;
            res_new = err_res(EC_TRUNC);
            phase_d = PH_FIN;
          end else begin
            desc_we = 1'b1;
            if (fs_q == RecLast) begin
              if (f3) begin
                res_hit = 1'b1;
                res_new = err_res(EC_EXTENT);
                phase_d = PH_FIN;
              end else if (f4) begin
                res_hit = 1'b1;
                res_new = err_res(EC_FUZZY);
                phase_d = PH_FIN;
              end else begin
                tend_d  = {1'b0, ts_q} + {1'b0, blk};
                base_d  = ts_q + RecBytes + cnt16 + fuzzy;
                room_d  = room0 - fuzzy;
                cnt_d   = cnt;
                tid_d   = desc_q[14];
                sidx_d  = '0;
                fs_d    = '0;
                phase_d = (cnt != '0) ? PH_DSC : PH_SKP;
              end
            end else begin
              fs_d = fs_q + 4'd1;
            end
          end
        end
        PH_DSC: begin
          desc_we = 1'b1;
          if (fs_q == RecLast) begin
            res_hit = 1'b1;
            if (f5) begin
              res_new = err_res(EC_SIZE);
              phase_d = PH_FIN;
            end else if (f6) begin
              res_new = err_res(EC_PAYLOAD);
              phase_d = PH_FIN;
            end else if (f7) begin
              res_new = err_res(EC_IDENT);
              phase_d = PH_FIN;
            end else if (f8) begin
              res_new = err_res(EC_DUP);
              phase_d = PH_FIN;
            end else begin
              ram_we         = 1'b1;
              rowv_d[tid_q]  = 1'b1;
              res_new.kind   = RK_SECTOR;
              res_new.err    = EC_NONE;
              res_new.trk    = desc_q[8][6:0];
              res_new.side   = desc_q[9][0];
              res_new.num    = desc_q[10];
              res_new.code   = desc_q[11][2:0];
              res_new.flags  = desc_q[14];
              res_new.off    = base_q + off;
              res_new.size   = psize;
              sidx_d         = sidx_q + 16'd1;
              fs_d           = '0;
              if (sidx_d >= cnt_q) begin
                phase_d = PH_SKP;
              end
            end
          end else begin
            fs_d = fs_q + 4'd1;
          end
        end
        default: begin
        end
      endcase

      // End of the current track block.
      if (((phase_d == PH_DSC) || (phase_d == PH_SKP)) && (pos_p1 >= tend_d)) begin
        if (seen_d != SeenMax) begin
          seen_d = seen_d + 9'd1;
        end
        if (item_i.last) begin
          res_hit = 1'b1;
          res_new = final_res(seen_d == {1'b0, decl_d});
          phase_d = PH_FIN;
        end else begin
          phase_d = PH_TRK;
          fs_d    = '0;
        end
      end

      // Last byte of the image: close it and clear per-image state.
      if (item_i.last) begin
        if (phase_d != PH_FIN) begin
          res_hit = 1'b1;
          res_new = err_res(EC_TRUNC);
        end
        phase_d = PH_HDR;
        fs_d    = '0;
        ts_d    = '0;
        tend_d  = '0;
        base_d  = '0;
        room_d  = '0;
        cnt_d   = '0;
        sidx_d  = '0;
        tid_d   = '0;
        decl_d  = '0;
        seen_d  = '0;
        rowv_d  = '0;
      end

      if (res_hit) begin
        res_d     = res_new;
        out_vld_d = 1'b1;
      end
    end
  end

  // Record buffer.
  always_ff @(posedge clk_i) begin
    if (desc_we) begin
      desc_q[fs_q] <= item_i.data;
    end
  end

  // Parse state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR;
      fs_q      <= '0;
      ts_q      <= '0;
      tend_q    <= '0;
      base_q    <= '0;
      room_q    <= '0;
      cnt_q     <= '0;
      sidx_q    <= '0;
      tid_q     <= '0;
      decl_q    <= '0;
      seen_q    <= '0;
      rowv_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      fs_q      <= fs_d;
      ts_q      <= ts_d;
      tend_q    <= tend_d;
      base_q    <= base_d;
      room_q    <= room_d;
      cnt_q     <= cnt_d;
      sidx_q    <= sidx_d;
      tid_q     <= tid_d;
      decl_q    <= decl_d;
      seen_q    <= seen_d;
      rowv_q    <= rowv_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end
endmodule

// ----- bench/sidv_checker.sv -----
// Predicts the validator results from the observed channels and compares them.
module sidv_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  image_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  result_kind_i,
  input  logic [3:0]  error_code_i,
  input  logic [6:0]  sector_track_i,
  input  logic        sector_side_i,
  input  logic [7:0]  sector_number_i,
  input  logic [2:0]  size_code_i,
  input  logic [7:0]  sector_flags_i,
  input  logic [31:0] payload_offset_i,
  input  logic [14:0] payload_size_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  import sidv_pkg::*;

  localparam logic [2:0] LenAddr = 3'd0;

  typedef enum logic [2:0] {
    PH_HDR  = 3'd0,
    PH_TRK  = 3'd1,
    PH_DESC = 3'd2,
    PH_SKIP = 3'd3,
    PH_DONE = 3'd4
  } phase_e;

  // Predictor state, one copy of the parser.
  logic [31:0] img_len;
  logic [31:0] byte_pos;
  phase_e      phase;
  logic [31:0] shift;
  logic [31:0] trk_start;
  logic [31:0] trk_block;
  logic [31:0] trk_fuzzy;
  logic [15:0] trk_count;
  logic [15:0] sec_idx;
  logic [7:0]  trk_id;
  logic [7:0]  rec [16];
  logic [7:0]  declared;
  logic [8:0]  tracks_done;
  bit          seen_keys [int];
  logic        err_latched;
  result_t     res;
  result_t     expected_q [$];

  // Clears the per-image state.
  task automatic start_image();
    byte_pos    = '0;
    phase       = PH_HDR;
    shift       = '0;
    trk_start   = '0;
    trk_block   = '0;
    trk_fuzzy   = '0;
    trk_count   = '0;
    sec_idx     = '0;
    trk_id      = '0;
    declared    = '0;
    tracks_done = '0;
    seen_keys.delete();
    err_latched = 1'b0;
  endtask

  function automatic logic [63:0] le32(input int o);
    return {32'd0, rec[o+3], rec[o+2], rec[o+1], rec[o]};
  endfunction

  task automatic raise_error(input error_code_e code);
    res         = '0;
    res.kind    = RK_ERROR;
    res.err     = code;
    err_latched = 1'b1;
    phase       = PH_DONE;
  endtask

  task automatic final_status();
    res = '0;
    if (tracks_done == {1'b0, declared}) begin
      res.kind = RK_ACCEPT;
    end else begin
      res.kind = RK_ERROR;
      res.err  = EC_TCOUNT;
    end
    phase = PH_DONE;
  endtask

  task automatic check_file_header(input logic [63:0] len, output bit hit);
    hit = 1'b0;
    if (len < 16 || rec[0] != MagicR || rec[1] != MagicS || rec[2] != MagicY ||
        rec[3] != 8'd0 || rec[4] != FmtVer || rec[5] != 8'd0) begin
      raise_error(EC_HEADER);
      hit = 1'b1;
    end else begin
      declared    = rec[10];
      tracks_done = '0;
      shift       = '0;
      if (len <= 16) begin
        final_status();
        hit = 1'b1;
      end else begin
        phase = PH_TRK;
      end
    end
  endtask

  task automatic check_track_header(input logic [63:0] len, output bit hit);
    logic [63:0] start, blk, fz, cnt, remain, desc_end;
    hit    = 1'b0;
    start  = {32'd0, trk_start};
    blk    = le32(0);
    fz     = le32(4);
    cnt    = {48'd0, rec[9], rec[8]};
    remain = (len > start) ? len - start : 64'd0;
    if (blk < 16 || blk > remain || cnt > (blk - 16) / 16) begin
      raise_error(EC_EXTENT);
      hit = 1'b1;
    end else begin
      desc_end = start + 16 + cnt * 16;
      if (fz > start + blk - desc_end) begin
        raise_error(EC_FUZZY);
        hit = 1'b1;
      end else begin
        trk_block = blk[31:0];
        trk_fuzzy = fz[31:0];
        trk_count = cnt[15:0];
        trk_id    = rec[14];
        sec_idx   = '0;
        shift     = '0;
        phase     = (cnt != 0) ? PH_DESC : PH_SKIP;
      end
    end
  endtask

  task automatic check_descriptor();
    logic [63:0] base, room, off, psize;
    int          key;
    base  = {32'd0, trk_start} + 16 + {48'd0, trk_count} * 16 + {32'd0, trk_fuzzy};
    room  = {32'd0, trk_start} + {32'd0, trk_block} - base;
    off   = le32(0);
    psize = '0;
    key   = 0;
    if (rec[11] > 8'd7) begin
      raise_error(EC_SIZE);
    end else begin
      psize = 64'd128 << rec[11];
      if (off > room || psize > room - off) begin
        raise_error(EC_PAYLOAD);
      end else if (rec[8] != {1'b0, trk_id[6:0]} || rec[9] != {7'd0, trk_id[7]}) begin
        raise_error(EC_IDENT);
      end else begin
        key = int'({rec[8][6:0], rec[9][0], rec[10]});
        if (seen_keys.exists(key)) begin
          raise_error(EC_DUP);
        end else begin
          seen_keys[key] = 1'b1;
          res       = '0;
          res.kind  = RK_SECTOR;
          res.err   = EC_NONE;
          res.trk   = rec[8][6:0];
          res.side  = rec[9][0];
          res.num   = rec[10];
          res.code  = rec[11][2:0];
          res.flags = rec[14];
          res.off   = base[31:0] + off[31:0];
          res.size  = psize[14:0];
          sec_idx   = sec_idx + 16'd1;
          shift     = '0;
          if (sec_idx >= trk_count) phase = PH_SKIP;
        end
      end
    end
  endtask

  // One image byte through the predictor.
  task automatic take_byte(input logic [7:0] b);
    logic [63:0] pos, len;
    bit          hit;
    pos = {32'd0, byte_pos};
    len = {32'd0, img_len};
    hit = 1'b0;
    res = '0;
    case (phase)
      PH_HDR: begin
        if (pos == 0 && len < 16) begin
          raise_error(EC_HEADER);
          hit = 1'b1;
        end else begin
          rec[shift[3:0]] = b;
          if (shift >= 15) check_file_header(len, hit);
          else shift++;
        end
      end
      PH_TRK: begin
        if (shift == 0) trk_start = pos[31:0];
        if (shift == 0 && len < pos + 16) begin
          raise_error(EC_TRUNC);
          hit = 1'b1;
        end else begin
          rec[shift[3:0]] = b;
          if (shift >= 15) check_track_header(len, hit);
          else shift++;
        end
      end
      PH_DESC: begin
        rec[shift[3:0]] = b;
        if (shift >= 15) begin
          check_descriptor();
          hit = 1'b1;
        end else begin
          shift++;
        end
      end
      default: ;
    endcase

    // End of the current track block.
    if (!err_latched && (phase == PH_DESC || phase == PH_SKIP) &&
        pos + 1 >= {32'd0, trk_start} + {32'd0, trk_block}) begin
      if (tracks_done < SeenMax) tracks_done++;
      if (pos + 1 >= len) begin
        final_status();
        hit = 1'b1;
      end else begin
        phase = PH_TRK;
        shift = '0;
      end
    end

    // Last byte of the image.
    if (pos + 1 >= len) begin
      if (phase != PH_DONE) begin
        raise_error(EC_TRUNC);
        hit = 1'b1;
      end
      if (hit) expected_q = {expected_q, res};
      start_image();
    end else begin
      byte_pos++;
      if (hit) expected_q = {expected_q, res};
    end
  endtask

  // Compare accepted results, then predict from accepted bytes and writes.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      img_len = 32'd16;
      foreach (rec[i]) rec[i] = '0;
      start_image();
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.kind  = result_kind_e'(result_kind_i);
        got.err   = error_code_e'(error_code_i);
        got.trk   = sector_track_i;
        got.side  = sector_side_i;
        got.num   = sector_number_i;
        got.code  = size_code_i;
        got.flags = sector_flags_i;
        got.off   = payload_offset_i;
        got.size  = payload_size_i;
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result transaction: kind %0d err %0d", got.kind, got.err);
        end else begin
          want = expected_q.pop_front();
          if (got.kind !== want.kind || got.err !== want.err || got.trk !== want.trk ||
              got.side !== want.side || got.num !== want.num || got.code !== want.code ||
              got.flags !== want.flags || got.off !== want.off ||
              got.size !== want.size) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("mismatch exp: kind %0d err %0d trk %0d side %0d num %0d code %0d",
                       want.kind, want.err, want.trk, want.side, want.num, want.code);
              $display("              flags %h off %h size %0d",
                       want.flags, want.off, want.size);
              $display("         got: kind %0d err %0d trk %0d side %0d num %0d code %0d",
                       got.kind, got.err, got.trk, got.side, got.num, got.code);
              $display("              flags %h off %h size %0d",
                       got.flags, got.off, got.size);
            end
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == LenAddr)
        img_len = pwdata_i;
      if (in_valid_i && !in_stall_i) take_byte(image_byte_i);
    end
    pending_o = expected_q.size();
  end

endmodule

// ----- bench/testbench.sv -----
// Stimulus and verdict for the disk image validator.
module testbench;
  import sidv_pkg::*;

  localparam logic [2:0] LenAddr = 3'd0;

  // Ways a generated image can be damaged.
  typedef enum int {
    M_CLEAN, M_MAGIC, M_TCOUNT, M_EXTENT, M_FUZZY, M_SIZE,
    M_PAYLOAD, M_IDENT, M_DUP, M_NOISE
  } damage_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  image_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  result_kind_o;
  logic [3:0]  error_code_o;
  logic [6:0]  sector_track_o;
  logic        sector_side_o;
  logic [7:0]  sector_number_o;
  logic [2:0]  size_code_o;
  logic [7:0]  sector_flags_o;
  logic [31:0] payload_offset_o;
  logic [14:0] payload_size_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending;
  int          bytes_sent;
  bit          tx_calm;
  bit          rx_calm;
  int          stall_left;
  logic [7:0]  img_q [$];

  stx_disk_image_validator_top u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .image_byte_i,
    .out_valid_o, .out_stall_i, .result_kind_o, .error_code_o,
    .sector_track_o, .sector_side_o, .sector_number_o, .size_code_o,
    .sector_flags_o, .payload_offset_o, .payload_size_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sidv_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .image_byte_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .result_kind_i(result_kind_o), .error_code_i(error_code_o),
    .sector_track_i(sector_track_o), .sector_side_i(sector_side_o),
    .sector_number_i(sector_number_o), .size_code_i(size_code_o),
    .sector_flags_i(sector_flags_o), .payload_offset_i(payload_offset_o),
    .payload_size_i(payload_size_o), .psel_i(psel), .penable_i(penable),
    .pwrite_i(pwrite), .pready_i(pready), .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver stalls at random unless calm.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!rx_calm && $urandom_range(0, 2) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= gap_len();
    end else begin
      out_stall_i <= 1'b0;
      stall_left  <= $urandom_range(0, 6);
    end
  end

  // Appends one byte to the image under construction.
  task automatic add_byte(input logic [7:0] b);
    img_q = {img_q, b};
  endtask

  task automatic push_le32(input logic [31:0] v);
    add_byte(v[7:0]);
    add_byte(v[15:8]);
    add_byte(v[23:16]);
    add_byte(v[31:24]);
  endtask

  task automatic push_random(input int n);
    repeat (n) add_byte(8'($urandom));
  endtask

  task automatic push_file_header(input logic [7:0] tracks);
    add_byte(MagicR);
    add_byte(MagicS);
    add_byte(MagicY);
    add_byte(8'd0);
    add_byte(FmtVer);
    add_byte(8'd0);
    push_random(4);
    add_byte(tracks);
    push_random(5);
  endtask

  // Builds one image, damaged where the mode says so: in the file header, in its last track, or at a random byte.
  task automatic build_image(input damage_e mode);
    int         ntr, ns, fz, room, maxp, tbase;
    int         codes [4];
    int         offs [4];
    logic [7:0] tb, id0, id, cw;
    logic [31:0] blk_w, fz_w, off_w;
    bit         last_trk;
    ntr   = $urandom_range(0, 3);
    tbase = $urandom_range(0, 120);
    push_file_header(8'((mode == M_TCOUNT) ? ntr + 1 : ntr));
    if (mode == M_MAGIC) img_q[$urandom_range(0, 5)] ^= 8'h01 << $urandom_range(0, 7);
    for (int t = 0; t < ntr; t++) begin
      last_trk = (t == ntr - 1);
      ns   = $urandom_range(0, 3);
      fz   = $urandom_range(0, 24);
      tb   = {1'($urandom_range(0, 1)), 7'(tbase + t)};
      maxp = 0;
      for (int s = 0; s < ns; s++) begin
        codes[s] = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 4) == 0) ? 2 : 1) : 0;
        if ((128 << codes[s]) > maxp) maxp = 128 << codes[s];
      end
      room = (ns != 0) ? maxp + $urandom_range(0, 40) : $urandom_range(0, 20);
      blk_w = 32'(16 + 16 * ns + fz + room);
      fz_w  = 32'(fz);
      if (last_trk && mode == M_EXTENT) blk_w = 32'hFFFF_FFF0 - 32'($urandom_range(0, 99));
      if (last_trk && mode == M_FUZZY) fz_w = 32'(fz + room + 1);
      push_le32(blk_w);
      push_le32(fz_w);
      add_byte(8'(ns));
      add_byte(8'd0);
      push_random(4);
      add_byte(tb);
      push_random(1);
      id0 = 8'($urandom);
      for (int s = 0; s < ns; s++) begin
        offs[s] = $urandom_range(0, room - (128 << codes[s]));
        id      = id0 + 8'(s);
        cw      = 8'(codes[s]);
        off_w   = 32'(offs[s]);
        if (last_trk && s == ns - 1) begin
          if (mode == M_SIZE) cw = 8'($urandom_range(8, 255));
          if (mode == M_PAYLOAD) off_w = 32'(room - (128 << codes[s]) + 1);
          if (mode == M_DUP && s > 0) id = id0;
        end
        push_le32(off_w);
        push_random(4);
        add_byte((last_trk && s == ns - 1 && mode == M_IDENT) ?
                 {1'b0, tb[6:0] ^ 7'h01} : {1'b0, tb[6:0]});
        add_byte({7'd0, tb[7]});
        add_byte(id);
        add_byte(cw);
        push_random(4);
      end
      push_random(fz + room);
    end
    if (mode == M_NOISE) img_q[$urandom_range(0, img_q.size() - 1)] = 8'($urandom);
  endtask

  // Streams the queued bytes, one transaction each, with random gaps unless calm.
  task automatic send_queue();
    int g;
    foreach (img_q[i]) begin
      g = tx_calm ? 0 : gap_len();
      if (g > 0) begin
        in_valid_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      in_valid_i   <= 1'b1;
      image_byte_i <= img_q[i];
      do @(negedge clk_i); while (in_stall_o);
      @(posedge clk_i);
      bytes_sent++;
    end
    in_valid_i <= 1'b0;
    img_q.delete();
  endtask

  // Holds off until every expected result has come and the pipe is empty.
  task automatic wait_idle();
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= LenAddr;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    damage_e mode;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    image_byte_i = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    bytes_sent   = 0;
    tx_calm      = 1'b0;
    rx_calm      = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short image: every byte is a one-byte image with a header error.
    write_length(32'd1);
    push_random(2);
    send_queue();
    wait_idle();

    // Header-only images: accepted, then a track count mismatch.
    write_length(32'd16);
    push_file_header(8'd0);
    push_file_header(8'd1);
    send_queue();
    wait_idle();

    // Truncated track header after a good file header.
    write_length(32'd20);
    push_file_header(8'd0);
    push_random(4);
    send_queue();
    wait_idle();

    // Length drops below a header mid-image.
    write_length(32'd40);
    push_random(5);
    send_queue();
    wait_idle();
    write_length(32'd8);
    push_random(11);
    send_queue();
    wait_idle();

    // Largest length, then cut short so the image ends unfinished.
    write_length(32'hFFFF_FFFF);
    push_file_header(8'd0);
    push_random(3);
    send_queue();
    wait_idle();
    write_length(32'd20);
    push_random(1);
    send_queue();
    wait_idle();

    // Random images, mostly well formed.
    while (bytes_sent < 1850) begin
      mode    = ($urandom_range(0, 9) < 5) ? M_CLEAN : damage_e'($urandom_range(1, 9));
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      build_image(mode);
      wait_idle();
      write_length(32'(img_q.size()));
      send_queue();
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- stx_disk_image_validator_top.f -----
src/sidv_pkg.sv
src/sidv_ram.sv
src/sidv_front.sv
src/sidv_fifo.sv
src/sidv_back.sv
src/stx_disk_image_validator_top.sv
bench/sidv_checker.sv
bench/testbench.sv
